### design/gss_pkg.sv
// shared types and constants for the geometric substep scheduler
package gss_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_POW_GO,
    S_POW_WAIT,
    S_OFF_GO,
    S_OFF_WAIT,
    S_CLAMP,
    S_EVAL,
    S_CHECK,
    S_FINAL
  } state_t;

  // register selects, taken from address bit 3
  localparam logic REG_SHRINK = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic [31:0] SHRINK_RESET = 32'h8000_0000;
  localparam logic [63:0] THRESH_RESET = 64'd0;

  typedef struct packed {
    logic [31:0] shrink;
    logic [63:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic        go;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mul_rsp_t;

endpackage

### design/gss_mul.sv
// shared 64x64 fixed-point multiplier, one 32x32 partial product per cycle
module gss_mul import gss_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic         busy_r, busy_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [1:0]   pp_sh_r, pp_sh_nxt;
  logic         pp_v_r, pp_v_nxt;
  logic         pp_last_r, pp_last_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  a_half, b_half;

  always_comb begin
    a_nxt       = a_r;
    b_nxt       = b_r;
    busy_nxt    = busy_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    done_nxt    = 1'b0;
    // halves: lo*lo, lo*hi, hi*lo, hi*hi
    a_half      = idx_r[1] ? a_r[63:32] : a_r[31:0];
    b_half      = idx_r[0] ? b_r[63:32] : b_r[31:0];
    pp_nxt      = 64'(a_half) * 64'(b_half);
    pp_sh_nxt   = 2'(idx_r[1]) + 2'(idx_r[0]);
    pp_v_nxt    = busy_r;
    pp_last_nxt = busy_r && (idx_r == 2'd3);

    if (req.go) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
      // rounding constant preloaded
      acc_nxt  = HALF;
    end else if (busy_r) begin
      idx_nxt = idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end

    if (pp_v_r) begin
      acc_nxt  = acc_r + (128'(pp_r) << {pp_sh_r, 5'd0});
      done_nxt = pp_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      idx_r     <= 2'd0;
      pp_v_r    <= 1'b0;
      pp_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      idx_r     <= idx_nxt;
      pp_v_r    <= pp_v_nxt;
      pp_last_r <= pp_last_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    pp_r    <= pp_nxt;
    pp_sh_r <= pp_sh_nxt;
    acc_r   <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r[FRAC_BITS +: 64];

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !busy_r && !pp_v_r)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done held longer than one cycle");

endmodule

### design/gss_cfg.sv
// configuration register file behind the apb port
module gss_cfg import gss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [31:0] shrink_r, shrink_nxt;
  logic [63:0] thresh_r, thresh_nxt;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    shrink_nxt = shrink_r;
    thresh_nxt = thresh_r;
    if (wr_en) begin
      case (paddr[3])
        REG_SHRINK: shrink_nxt = pwdata[31:0];
        REG_THRESH: thresh_nxt = pwdata;
        default:    shrink_nxt = shrink_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r <= SHRINK_RESET;
      thresh_r <= THRESH_RESET;
    end else begin
      shrink_r <= shrink_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  assign prdata     = (paddr[3] == REG_THRESH) ? thresh_r : {32'd0, shrink_r};
  assign cfg.shrink = shrink_r;
  assign cfg.thresh = thresh_r;

endmodule

### design/geometric_substep_scheduler_top.sv
// Splits one interval [start, end) into geometrically shrinking sub-intervals. An item is
// taken when start is high and busy is low; an empty interval returns at once with no
// result. Each candidate end takes two products on the shared 64x64 multiplier (each an
// issue, four partial products, a final accumulate and the result hand-back) and the
// clamp, eval and check states. With k candidate ends (k up to MAX_SUBSTEPS) busy stays
// high until it drops as the last result shows; no next item is taken before that.
// Results appear as one-cycle out_valid strobes and must be captured when they show; the
// last one has out_last_of_run set.
module geometric_substep_scheduler_top import gss_pkg::*; #(
  parameter int MAX_SUBSTEPS  = 64,
  parameter int FRACTION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_interval_start,
  input  logic [63:0] in_interval_end,
  output logic        out_valid,
  output logic [63:0] out_sub_begin,
  output logic [63:0] out_sub_finish,
  output logic        out_last_of_run
);

  localparam int PW    = FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(MAX_SUBSTEPS + 1);
  localparam logic [PW-1:0] ONE = PW'(1) << FRACTION_BITS;

  cfg_t     cfg;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic [PW-1:0] r_fb;
  logic [PW-1:0] frac;

  state_t state_r, state_nxt;
  logic [63:0]    start_r, start_nxt;
  logic [63:0]    end_r, end_nxt;
  logic [63:0]    macro_r, macro_nxt;
  logic [PW-1:0]  power_r, power_nxt;
  logic [63:0]    curr_r, curr_nxt;
  logic [63:0]    prev_r, prev_nxt;
  logic [63:0]    rem_r, rem_nxt;
  logic [63:0]    pbegin_r, pbegin_nxt;
  logic [63:0]    pfinish_r, pfinish_nxt;
  logic           pvalid_r, pvalid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic [63:0]    obegin_r, obegin_nxt;
  logic [63:0]    ofinish_r, ofinish_nxt;
  logic           olast_r, olast_nxt;

  gss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gss_mul #(.FRAC_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // ratio from q0.32 to the working fraction width
  generate
    if (FRACTION_BITS >= 32) begin : g_ratio_wide
      assign r_fb = PW'(cfg.shrink) << (FRACTION_BITS - 32);
    end else begin : g_ratio_narrow
      logic [32:0] r_round;
      assign r_round = {1'b0, cfg.shrink} + (33'd1 << (31 - FRACTION_BITS));
      assign r_fb    = PW'(r_round >> (32 - FRACTION_BITS));
    end
  endgenerate

  assign frac = (power_r >= ONE) ? '0 : ONE - power_r;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    macro_nxt   = macro_r;
    power_nxt   = power_r;
    curr_nxt    = curr_r;
    prev_nxt    = prev_r;
    rem_nxt     = rem_r;
    pbegin_nxt  = pbegin_r;
    pfinish_nxt = pfinish_r;
    pvalid_nxt  = pvalid_r;
    cnt_nxt     = cnt_r;
    ovalid_nxt  = 1'b0;
    obegin_nxt  = obegin_r;
    ofinish_nxt = ofinish_r;
    olast_nxt   = olast_r;
    mreq.go     = 1'b0;
    mreq.a      = 64'(power_r);
    mreq.b      = 64'(r_fb);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          start_nxt  = in_interval_start;
          end_nxt    = in_interval_end;
          macro_nxt  = in_interval_end - in_interval_start;
          power_nxt  = ONE;
          prev_nxt   = in_interval_start;
          pvalid_nxt = 1'b0;
          cnt_nxt    = '0;
          if (in_interval_start < in_interval_end) begin
            state_nxt = S_POW_GO;
          end
        end
      end
      S_POW_GO: begin
        mreq.go   = 1'b1;
        state_nxt = S_POW_WAIT;
      end
      S_POW_WAIT: begin
        if (mrsp.done) begin
          power_nxt = mrsp.res[PW-1:0];
          state_nxt = S_OFF_GO;
        end
      end
      S_OFF_GO: begin
        mreq.go   = 1'b1;
        mreq.a    = macro_r;
        mreq.b    = 64'(frac);
        state_nxt = S_OFF_WAIT;
      end
      S_OFF_WAIT: begin
        if (mrsp.done) begin
          curr_nxt  = start_r + mrsp.res;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (curr_r > end_r) begin
          curr_nxt = end_r;
        end
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (curr_r <= prev_r) begin
          // ends stopped advancing
          state_nxt = S_FINAL;
        end else begin
          if (pvalid_r) begin
            ovalid_nxt  = 1'b1;
            obegin_nxt  = pbegin_r;
            ofinish_nxt = pfinish_r;
            olast_nxt   = 1'b0;
            cnt_nxt     = cnt_r + CNT_W'(1);
          end
          pbegin_nxt  = prev_r;
          pfinish_nxt = curr_r;
          pvalid_nxt  = 1'b1;
          prev_nxt    = curr_r;
          rem_nxt     = end_r - curr_r;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rem_r <= cfg.thresh || cnt_r >= CNT_W'(MAX_SUBSTEPS - 1)) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_POW_GO;
        end
      end
      S_FINAL: begin
        // stretch the pending piece to the end, or emit the whole interval
        ovalid_nxt  = 1'b1;
        obegin_nxt  = pvalid_r ? pbegin_r : start_r;
        ofinish_nxt = end_r;
        olast_nxt   = 1'b1;
        pbegin_nxt  = pvalid_r ? pbegin_r : start_r;
        pfinish_nxt = end_r;
        pvalid_nxt  = 1'b1;
        prev_nxt    = end_r;
        cnt_nxt     = cnt_r + CNT_W'(1);
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pvalid_r <= 1'b0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pvalid_r <= pvalid_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    macro_r   <= macro_nxt;
    power_r   <= power_nxt;
    curr_r    <= curr_nxt;
    prev_r    <= prev_nxt;
    rem_r     <= rem_nxt;
    pbegin_r  <= pbegin_nxt;
    pfinish_r <= pfinish_nxt;
    obegin_r  <= obegin_nxt;
    ofinish_r <= ofinish_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_sub_begin   = obegin_r;
  assign out_sub_finish  = ofinish_r;
  assign out_last_of_run = olast_r;

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy)
    else $error("still busy after the final item");

  a_piece_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sub_begin < out_sub_finish)
    else $error("sub-interval does not advance");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SUBSTEPS))
    else $error("emitted more sub-intervals than allowed");

endmodule

### bench/tb.sv
// self-checking testbench for the geometric substep scheduler
`timescale 1ns / 1ps

module tb;
  import gss_pkg::*;

  localparam int MAX_STEPS = 64;
  localparam int FRAC_BITS = 32;
  localparam logic [63:0] Q_ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 40;
  localparam int unsigned RANDOM_PHASES = 5;

  typedef struct {
    logic [63:0] sub_begin;
    logic [63:0] sub_finish;
    logic        last_of_run;
  } substep_t;

  class substep_checker;
    logic [31:0] shrink;
    logic [63:0] thresh;
    logic [63:0] power_term;
    logic [63:0] previous_end;
    logic [63:0] pending_begin;
    logic [63:0] pending_finish;
    logic        pending_valid;
    int unsigned emitted_count;
    substep_t    expected_substeps[$];
    int unsigned errors;

    function new();
      shrink = SHRINK_RESET;
      thresh = THRESH_RESET;
      power_term = Q_ONE;
      previous_end = '0;
      pending_begin = '0;
      pending_finish = '0;
      pending_valid = 1'b0;
      emitted_count = 0;
      errors = 0;
    endfunction

    // round-half-up of a*b / 2^FRAC_BITS, full-width product
    function logic [63:0] scale_round(logic [63:0] a, logic [63:0] b);
      logic [128:0] p;
      p = {65'd0, a} * {65'd0, b};
      p = p + (129'd1 << (FRAC_BITS - 1));
      return p[FRAC_BITS +: 64];
    endfunction

    function void push_substep(logic [63:0] b, logic [63:0] f, logic l);
      substep_t s;
      s.sub_begin = b;
      s.sub_finish = f;
      s.last_of_run = l;
      expected_substeps.push_back(s);
    endfunction

    function void set_config(logic [31:0] r, logic [63:0] t);
      shrink = r;
      thresh = t;
    endfunction

    function void note_interval(logic [63:0] s, logic [63:0] e);
      logic [63:0] ratio;
      logic [63:0] span;
      logic [63:0] frac;
      logic [63:0] curr;
      ratio = {32'd0, shrink};
      power_term = Q_ONE;
      previous_end = s;
      pending_valid = 1'b0;
      pending_begin = '0;
      pending_finish = '0;
      emitted_count = 0;
      if (s >= e) return;
      span = e - s;
      forever begin
        power_term = scale_round(power_term, ratio);
        frac = (power_term >= Q_ONE) ? 64'd0 : Q_ONE - power_term;
        curr = s + scale_round(span, frac);
        if (curr > e) curr = e;
        if (curr <= previous_end) break;
        if (pending_valid) begin
          push_substep(pending_begin, pending_finish, 1'b0);
          emitted_count++;
        end
        pending_begin = previous_end;
        pending_finish = curr;
        pending_valid = 1'b1;
        previous_end = curr;
        if (e - previous_end <= thresh) break;
        if (emitted_count >= MAX_STEPS - 1) break;
      end
      // stretch the last piece to the end, or take the whole interval
      if (!pending_valid) begin
        pending_begin = s;
        pending_valid = 1'b1;
      end
      pending_finish = e;
      previous_end = e;
      push_substep(pending_begin, pending_finish, 1'b1);
      emitted_count++;
    endfunction

    function void check_substep(logic [63:0] b, logic [63:0] f, logic l);
      substep_t want;
      if (expected_substeps.size() == 0) begin
        $error("unexpected sub-interval %h..%h last %b", b, f, l);
        errors++;
        return;
      end
      want = expected_substeps.pop_front();
      if (want.sub_begin !== b) begin
        $error("sub_begin: expected %h, got %h", want.sub_begin, b);
        errors++;
      end
      if (want.sub_finish !== f) begin
        $error("sub_finish: expected %h, got %h", want.sub_finish, f);
        errors++;
      end
      if (want.last_of_run !== l) begin
        $error("last_of_run: expected %b, got %b", want.last_of_run, l);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_substeps.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_interval_start = '0;
  logic [63:0] in_interval_end = '0;
  logic        out_valid;
  logic [63:0] out_sub_begin;
  logic [63:0] out_sub_finish;
  logic        out_last_of_run;

  substep_checker chk = new();
  logic           idle_en = 1'b1;
  int unsigned    cycle_count = 0;

  geometric_substep_scheduler_top #(
    .MAX_SUBSTEPS (MAX_STEPS),
    .FRACTION_BITS(FRAC_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_interval_start(in_interval_start),
    .in_interval_end  (in_interval_end),
    .out_valid        (out_valid),
    .out_sub_begin    (out_sub_begin),
    .out_sub_finish   (out_sub_finish),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) chk.check_substep(out_sub_begin, out_sub_finish, out_last_of_run);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // both registers, back to back, psel held across the pair
  task automatic write_cfg(input logic [31:0] r, input logic [63:0] t);
    for (int i = 0; i < 2; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= (i == 0) ? {REG_SHRINK, 3'b000} : {REG_THRESH, 3'b000};
      pwdata <= (i == 0) ? {32'd0, r} : t;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    chk.set_config(r, t);
  endtask

  task automatic send_interval(input logic [63:0] s, input logic [63:0] e);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      // sometimes let the block finish first so the gap lands on an idle block
      if ($urandom_range(0, 1) == 0) begin
        while (busy) @(posedge clk);
      end
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_interval_start <= s;
    in_interval_end <= e;
    do @(posedge clk); while (busy);
    chk.note_interval(s, e);
  endtask

  // all results in, then let a trailing empty item or close-out finish
  task automatic wait_drained();
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random_interval();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] span;
    logic [63:0] room;
    if ($urandom_range(0, 9) == 0) begin
      // empty or reversed interval
      a = rand64();
      b = ($urandom_range(0, 1) == 0) ? a : rand64();
      if (a < b) send_interval(b, a);
      else send_interval(a, b);
    end else begin
      span = rand64() >> $urandom_range(0, 63);
      room = ALL_ONES - span;
      a = rand64();
      if (room != ALL_ONES) a = a % (room + 64'd1);
      send_interval(a, a + span);
    end
  endtask

  initial begin
    logic [31:0] r;
    logic [63:0] t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: halving, no threshold
    send_interval(64'd100, 64'd100);
    send_interval(64'd200, 64'd100);
    send_interval(64'd0, ALL_ONES);
    send_interval(ALL_ONES - 64'd1, ALL_ONES);
    send_interval(64'd0, 64'd1);
    send_interval(64'd1000, 64'd1003);
    send_interval(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    start <= 1'b0;
    wait_drained();

    // zero factor: whole interval at once
    write_cfg(32'd0, 64'd0);
    send_interval(64'd10, 64'd1000);
    send_interval(64'd0, ALL_ONES);
    start <= 1'b0;
    wait_drained();

    // factor near one: step limit on a huge span, no advance on a short one
    write_cfg(32'hFFFF_FFFF, 64'd0);
    send_interval(64'd0, ALL_ONES);
    send_interval(64'd5, 64'd100);
    send_interval(64'h8000_0000_0000_0000, ALL_ONES);
    start <= 1'b0;
    wait_drained();

    // tiny factor, threshold at maximum
    write_cfg(32'd1, ALL_ONES);
    send_interval(64'd0, ALL_ONES);
    send_interval(64'd100, 64'd200);
    start <= 1'b0;
    wait_drained();

    write_cfg(32'hC000_0000, 64'd1000);
    send_interval(64'd0, 64'd1_000_000);
    send_interval(ALL_ONES - 64'd123_456_789, ALL_ONES);
    send_interval(64'hFFFF_FFFF, 64'h1_0000_0000_0000);
    start <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: r = 32'd1;
        1: r = 32'hFFFF_FFFF;
        2: r = 32'h8000_0000 | $urandom;
        default: r = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: t = 64'd0;
        1: t = ALL_ONES;
        2: t = rand64();
        default: t = rand64() >> $urandom_range(8, 63);
      endcase
      write_cfg(r, t);
      // no idling in the closing phase
      idle_en = (ph != RANDOM_PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_interval();
      start <= 1'b0;
      wait_drained();
    end

    repeat (1200) @(posedge clk);
    if (chk.errors == 0 && chk.outstanding() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
